### hw/rtl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 digest core.
// Used by md5_ctrl, md5_dpath and md5_message_digest_core; no dependencies.
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_upper;
    logic [63:0] digest_lower;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_EXTRA,
    FIN_LAST
  } fin_t;

  typedef struct packed {
    logic       put_byte;
    logic       put_pad;
    logic       load_work;
    logic       round_en;
    logic [5:0] round;
    logic       add_en;
    logic       second_blk;
    logic       emit;
  } md5_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pad_extra;
  } md5_sts_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] FILL_EXTRA_MIN = 6'd56;
  localparam logic [3:0] LEN_LO_IDX     = 4'd14;
  localparam logic [3:0] LEN_HI_IDX     = 4'd15;
  localparam logic [4:0] WORDS_ALL      = 5'd16;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = lo * 4'd5 + 4'd1;
      2'd2:    g = lo * 4'd3 + 4'd5;
      default: g = lo * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

### hw/rtl/md5_ctrl.sv
// Controller state machine for the MD5 digest core: handshakes, sequencing, rounds.
// Depends on md5_pkg; drives md5_dpath through md5_cmd_t and reads md5_sts_t.
module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_has_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output md5_pkg::md5_cmd_t cmd,
  input  md5_pkg::md5_sts_t sts
);

  md5_pkg::state_t state_r, state_nxt;
  md5_pkg::fin_t   fin_r, fin_nxt;
  logic [5:0]      rnd_r, rnd_nxt;
  logic            last_pend_r, last_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            acc;
  logic            out_free;

  assign acc      = in_valid && (state_r == md5_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    rnd_nxt       = rnd_r;
    last_pend_nxt = last_pend_r;
    case (state_r)
      md5_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_has_byte && sts.block_full) begin
            state_nxt     = md5_pkg::ST_INIT;
            last_pend_nxt = in_last_byte;
          end else if (in_last_byte) begin
            state_nxt = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_INIT: begin
        state_nxt = md5_pkg::ST_ROUND;
        rnd_nxt   = 6'd0;
      end
      md5_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == md5_pkg::LAST_ROUND) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        case (fin_r)
          md5_pkg::FIN_NONE: begin
            state_nxt = last_pend_r ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
          end
          md5_pkg::FIN_EXTRA: begin
            state_nxt = md5_pkg::ST_INIT;
            fin_nxt   = md5_pkg::FIN_LAST;
          end
          md5_pkg::FIN_LAST: begin
            state_nxt = md5_pkg::ST_EMIT;
          end
          default: begin
            state_nxt = md5_pkg::ST_IDLE;
          end
        endcase
      end
      md5_pkg::ST_PAD: begin
        state_nxt     = md5_pkg::ST_INIT;
        last_pend_nxt = 1'b0;
        fin_nxt       = sts.pad_extra ? md5_pkg::FIN_EXTRA : md5_pkg::FIN_LAST;
      end
      md5_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = md5_pkg::ST_IDLE;
          fin_nxt   = md5_pkg::FIN_NONE;
        end
      end
      default: begin
        state_nxt = md5_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.put_byte   = acc && in_has_byte;
    cmd.put_pad    = (state_r == md5_pkg::ST_PAD);
    cmd.load_work  = (state_r == md5_pkg::ST_INIT);
    cmd.round_en   = (state_r == md5_pkg::ST_ROUND);
    cmd.round      = rnd_r;
    cmd.add_en     = (state_r == md5_pkg::ST_ADD);
    cmd.second_blk = (state_r == md5_pkg::ST_ADD) && (fin_r == md5_pkg::FIN_EXTRA);
    cmd.emit       = (state_r == md5_pkg::ST_EMIT) && out_free;
    out_valid_nxt  = cmd.emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5_pkg::ST_IDLE;
      fin_r       <= md5_pkg::FIN_NONE;
      rnd_r       <= 6'd0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      rnd_r       <= rnd_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != md5_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_rounds_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_ROUND && rnd_r != md5_pkg::LAST_ROUND)
    |=> (state_r == md5_pkg::ST_ROUND))
    else $error("round sequence left early");

  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == md5_pkg::ST_EMIT))
    else $error("digest shown without finishing a message");

  a_final_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_ADD && fin_r == md5_pkg::FIN_LAST)
    |=> (state_r == md5_pkg::ST_EMIT))
    else $error("final block did not lead to emit");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_EMIT && out_valid_r && out_stall)
    |=> (state_r == md5_pkg::ST_EMIT && out_valid_r))
    else $error("digest overwritten while output stalled");

endmodule

### hw/rtl/md5_dpath.sv
// Datapath for the MD5 digest core: block words, chaining words, round logic, output word.
// Depends on md5_pkg; controlled by md5_ctrl through md5_cmd_t.
module md5_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          data_byte,
  input  md5_pkg::md5_cmd_t   cmd,
  output md5_pkg::md5_sts_t   sts,
  output md5_pkg::out_word_t  out_data
);

  logic [31:0]        chain_r [4];
  logic [31:0]        blk_r [16];
  logic [31:0]        a_r, b_r, c_r, d_r;
  logic [5:0]         fill_r;
  logic [63:0]        bitcnt_r;
  logic               mask_on_r;
  logic               len_on_r;
  logic [4:0]         limit_r;
  md5_pkg::out_word_t out_data_r;

  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [5:0]  fill_inc;
  logic [6:0]  fill_rnd;
  logic [3:0]  g;
  logic [31:0] m;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_new;

  assign wr_en    = cmd.put_byte || cmd.put_pad;
  assign wr_byte  = cmd.put_pad ? md5_pkg::PAD_BYTE : data_byte;
  assign fill_inc = fill_r + 6'd1;
  assign fill_rnd = {1'b0, fill_inc} + 7'd3;

  assign sts.block_full = (fill_r == md5_pkg::FILL_LAST);
  assign sts.pad_extra  = (fill_r >= md5_pkg::FILL_EXTRA_MIN);

  always_comb begin
    g = md5_pkg::msg_index(cmd.round);
    if (len_on_r && g == md5_pkg::LEN_LO_IDX) begin
      m = bitcnt_r[31:0];
    end else if (len_on_r && g == md5_pkg::LEN_HI_IDX) begin
      m = bitcnt_r[63:32];
    end else if (mask_on_r && {1'b0, g} >= limit_r) begin
      m = 32'd0;
    end else begin
      m = blk_r[g];
    end
    case (cmd.round[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + f + md5_pkg::sine_k(cmd.round) + m;
    b_new = b_r + md5_pkg::rotl32(sum, md5_pkg::rot_amount(cmd.round));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
      fill_r     <= 6'd0;
      bitcnt_r   <= 64'd0;
      mask_on_r  <= 1'b0;
      len_on_r   <= 1'b0;
      limit_r    <= 5'd0;
    end else if (cmd.emit) begin
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
      fill_r     <= 6'd0;
      bitcnt_r   <= 64'd0;
      mask_on_r  <= 1'b0;
      len_on_r   <= 1'b0;
      limit_r    <= 5'd0;
    end else begin
      if (wr_en) begin
        fill_r <= fill_inc;
      end
      if (cmd.put_byte) begin
        bitcnt_r <= bitcnt_r + md5_pkg::BITS_PER_BYTE;
      end
      if (cmd.put_pad) begin
        mask_on_r <= 1'b1;
        len_on_r  <= !sts.pad_extra;
        limit_r   <= (fill_inc == 6'd0) ? md5_pkg::WORDS_ALL : fill_rnd[6:2];
      end
      if (cmd.add_en) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
      if (cmd.second_blk) begin
        limit_r  <= 5'd0;
        len_on_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (fill_r[1:0] == 2'd0) begin
        blk_r[fill_r[5:2]] <= {24'd0, wr_byte};
      end else begin
        blk_r[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= wr_byte;
      end
    end
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.round_en) begin
      a_r <= d_r;
      b_r <= b_new;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (cmd.emit) begin
      out_data_r.digest_upper <= {md5_pkg::swap_bytes(chain_r[0]),
                                  md5_pkg::swap_bytes(chain_r[1])};
      out_data_r.digest_lower <= {md5_pkg::swap_bytes(chain_r[2]),
                                  md5_pkg::swap_bytes(chain_r[3])};
    end
  end

  assign out_data = out_data_r;

endmodule

### hw/rtl/md5_message_digest_core.sv
// Top level of the MD5 digest core: streams bytes in, returns one digest per message.
// Depends on md5_pkg, md5_ctrl and md5_dpath.
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid / in_stall   md5_pkg::in_word_t (byte, has, last)
//   out_     output     out_valid / out_stall md5_pkg::out_word_t (128-bit digest)
//
// A byte that does not complete a block is taken and stored in the block words while the controller is idle.
// The 64th byte of a block starts a compression: load, 64 rounds, add.
// Finishing a message takes a pad step, one or two compressions and an emit step.
// The round logic is one shared unit, so no byte is taken while a block is compressed.
// Reset is synchronous and active low; the chaining words return to the initial values.
// A stalled digest waits in the output register; a new message is taken meanwhile.
module md5_message_digest_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::out_word_t out_data
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_has_byte  (in_data.has_byte),
    .in_last_byte (in_data.last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  md5_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_data.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
